// ----- rtl/core/wrs_pkg.sv -----
// Shared types, codes and default sizes for the weighted roulette selector.
package wrs_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int TOTAL_W   = 22;
   localparam int PICKS_W   = 7;
   localparam int IDX_OUT_W = 6;
   localparam int WEIGHT_W  = 16;
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 2;

   // Scan accumulator saturates here, above any draw value.
   localparam int CUM_W = TOTAL_W + 1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SELECT = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_LIMIT = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [WEIGHT_W-1:0] weight;
      logic [TOTAL_W-1:0]  draw;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] index;
      logic [WEIGHT_W-1:0]  picked_weight;
      logic [TOTAL_W-1:0]   remaining_total;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic init;
      logic valid;
      logic first_mode;
   } scan_ctl_type;

   typedef struct packed {
      logic hit;
      logic found;
   } scan_sts_type;

endpackage

// ----- rtl/core/wrs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wrs_scan.sv -----
// Shared accumulate-and-compare unit that walks the table one entry per cycle.
module wrs_scan
   import wrs_pkg::*;
#(
   parameter int IDX_W       = 6,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scan_ctl_type           ctl,
   input  logic [TOTAL_W-1:0]     draw,
   input  logic [IDX_W-1:0]       rd_idx,
   input  logic                   rd_used,
   input  logic [WEIGHT_BITS-1:0] rd_weight,
   output scan_sts_type           sts,
   output logic [IDX_W-1:0]       pick_idx,
   output logic [WEIGHT_BITS-1:0] pick_w
);

   localparam int SUM_W = ((WEIGHT_BITS > CUM_W) ? WEIGHT_BITS : CUM_W) + 1;
   localparam logic [SUM_W-1:0] CUM_SAT = SUM_W'({CUM_W{1'b1}});

   logic [CUM_W-1:0]       cum_ff, cum_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       pick_idx_ff, pick_idx_in;
   logic [WEIGHT_BITS-1:0] pick_w_ff, pick_w_in;
   logic [SUM_W-1:0]       sum;
   logic                   take;

   always_comb begin
      sum = SUM_W'(cum_ff) + SUM_W'(rd_weight);
      // clamp: anything past the saturation point already exceeds every draw
      if (sum > CUM_SAT) begin
         sum = CUM_SAT;
      end
   end

   assign take = ctl.valid && !rd_used;

   always_comb begin
      cum_in      = cum_ff;
      found_in    = found_ff;
      pick_idx_in = pick_idx_ff;
      pick_w_in   = pick_w_ff;
      if (ctl.init) begin
         cum_in   = '0;
         found_in = 1'b0;
      end else if (take) begin
         cum_in      = sum[CUM_W-1:0];
         found_in    = 1'b1;
         pick_idx_in = rd_idx;
         pick_w_in   = rd_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      cum_ff      <= cum_in;
      pick_idx_ff <= pick_idx_in;
      pick_w_ff   <= pick_w_in;
   end

   assign sts.hit   = take && (ctl.first_mode || (sum >= SUM_W'(draw)));
   assign sts.found = found_ff;
   assign pick_idx  = pick_idx_ff;
   assign pick_w    = pick_w_ff;

endmodule

// ----- rtl/core/weighted_roulette_select.sv -----
// Weighted roulette selection without replacement over a table of weights.
//
// Input channel: an item (req_data) is taken at a rising edge with start high
// and busy low. Opcodes: clear, append one weight, select one entry.
// Result channel: every item gives one result on rsp_data, shown for exactly one
// cycle with rsp_valid high; the receiver cannot stall it.
// Configuration: csr_wr_en / csr_wr_data write max_picks; write only while idle.
// Latency: clear, append, an unused opcode, and selects that are refused (pick
// limit reached or empty table) return their result the cycle after acceptance
// and keep busy low, so they may follow each other every cycle.
// A select that scans holds busy high until it settles on an entry or has walked
// all N loaded entries; its result shows in the first cycle with busy low again,
// and the next transfer can come no earlier.
// The walk is set by the single read port of the weight RAM: one entry is read,
// accumulated and compared per cycle.
// Reset (synchronous, active high) empties the table, zeroes the total, the
// pick count and max_picks, and returns the sequencer to idle. The RAM itself
// is not cleared; only entries below the loaded count are ever read.
module weighted_roulette_select
   import wrs_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [PICKS_W-1:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > PICKS_W) ? CNT_W : PICKS_W;
   localparam int WORD_W = WEIGHT_BITS + 1;
   localparam int ADD_W  = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

   fsm_state_type      state_ff, state_in;
   logic [PICKS_W-1:0] max_picks_ff, max_picks_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PICKS_W-1:0] picks_ff, picks_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [TOTAL_W-1:0] draw_ff, draw_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   scan_done;
   logic [WEIGHT_BITS-1:0] app_w;
   logic [ADD_W-1:0]       app_sum;
   logic [TOTAL_W-1:0]     app_total;
   logic [TOTAL_W-1:0]     sub_total;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic [WORD_W-1:0]      ram_rdata;

   scan_ctl_type           scan_ctl;
   scan_sts_type           scan_sts;
   logic [IDX_W-1:0]       pick_idx;
   logic [WEIGHT_BITS-1:0] pick_w;

   assign busy   = (state_ff != FSM_IDLE);
   assign accept = start && !busy;

   assign app_w   = WEIGHT_BITS'(req_data.weight);
   assign app_sum = ADD_W'(total_ff) + ADD_W'(app_w);
   assign app_total = (app_sum > ADD_W'(TOTAL_MAX)) ? TOTAL_MAX : app_sum[TOTAL_W-1:0];
   assign sub_total = (ADD_W'(total_ff) >= ADD_W'(pick_w))
                    ? TOTAL_W'(ADD_W'(total_ff) - ADD_W'(pick_w)) : '0;

   assign scan_done = scan_sts.hit || (!rd_pend_ff && (iss_ff == count_ff));

   wrs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   wrs_scan #(
      .IDX_W       (IDX_W),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .draw      (draw_ff),
      .rd_idx    (rd_idx_ff),
      .rd_used   (ram_rdata[WORD_W-1]),
      .rd_weight (ram_rdata[WEIGHT_BITS-1:0]),
      .sts       (scan_sts),
      .pick_idx  (pick_idx),
      .pick_w    (pick_w)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && (op_type'(req_data.opcode) == OP_SELECT)
                && (picks_ff < max_picks_ff) && (count_ff != '0)) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (scan_done) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      max_picks_in = csr_wr_en ? csr_wr_data : max_picks_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      picks_in     = picks_ff;
      iss_in       = iss_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      draw_in      = draw_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IDX_W-1:0];
      ram_wdata    = {1'b0, app_w};
      scan_ctl     = '0;
      scan_ctl.first_mode = first_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.remaining_total = total_ff;
               unique case (op_type'(req_data.opcode))
                  OP_CLEAR: begin
                     // used marks need no sweep: append rewrites them
                     count_in = '0;
                     total_in = '0;
                     picks_in = '0;
                     rsp_data_in.remaining_total = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff == CNT_FULL) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                        total_in = app_total;
                        rsp_data_in.index = IDX_OUT_W'(count_ff);
                        rsp_data_in.remaining_total = app_total;
                     end
                  end
                  OP_SELECT: begin
                     if (picks_ff >= max_picks_ff) begin
                        rsp_data_in.status = STAT_LIMIT;
                     end else if (count_ff == '0) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        rsp_valid_in  = 1'b0;
                        scan_ctl.init = 1'b1;
                        iss_in        = '0;
                        draw_in       = req_data.draw;
                        first_in      = CMP_W'(count_ff) <= CMP_W'(max_picks_ff);
                     end
                  end
                  OP_NOP: begin
                     // ignored: report the current total only
                  end
                  default: begin
                     rsp_data_in.status = STAT_OK;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            scan_ctl.valid = rd_pend_ff;
            // issue the next read one entry ahead of the compare
            if (iss_ff != count_ff) begin
               iss_in     = iss_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = iss_ff[IDX_W-1:0];
            end
         end
         FSM_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            if (scan_sts.found) begin
               ram_we    = 1'b1;
               ram_waddr = pick_idx;
               ram_wdata = {1'b1, pick_w};
               total_in  = sub_total;
               picks_in  = picks_ff + 1'b1;
               rsp_data_in.index           = IDX_OUT_W'(pick_idx);
               rsp_data_in.picked_weight   = WEIGHT_W'(pick_w);
               rsp_data_in.remaining_total = sub_total;
               rsp_data_in.status          = STAT_OK;
            end else begin
               rsp_data_in.remaining_total = total_ff;
               rsp_data_in.status          = STAT_EMPTY;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         max_picks_ff <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         picks_ff     <= '0;
         iss_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_picks_ff <= max_picks_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         picks_ff     <= picks_in;
         iss_ff       <= iss_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      draw_ff     <= draw_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/wrs_checker.sv -----
// Port-level checker for the weighted roulette selector, bound to the top level.
module wrs_checker
   import wrs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input req_type            req_data,
   input logic               rsp_valid,
   input rsp_type            rsp_data
);

   // busy only rises on a transfer into the block
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted item");

   // a result always lands when the sequencer is back at idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // a result follows either an accepted item or a finishing scan
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a cause");

   // a clear transfer returns an all-zero result next cycle
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && start && !busy && (req_data.opcode == OP_CLEAR)) |->
         (rsp_valid && (rsp_data == '0)))
      else $error("clear result not zero");

   // only a successful pick carries a weight
   a_fail_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STAT_OK)) |-> (rsp_data.picked_weight == '0))
      else $error("refused item reported a weight");

endmodule

bind weighted_roulette_select wrs_checker u_wrs_checker (.*);

// ----- test/wrs_monitor.sv -----
// Transfer monitor for the weighted roulette selector: predicts each result and compares it.
module wrs_monitor
   import wrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [PICKS_W-1:0] csr_wr_data,
   output int                 n_errors,
   output int                 n_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Own copy of the selector state and its one register.
   logic [WEIGHT_BITS_DEF-1:0] weights_m [MAX_ENTRIES_DEF];
   logic [MAX_ENTRIES_DEF-1:0] used_v;
   int unsigned                loaded;
   int unsigned                picks;
   logic [TOTAL_W-1:0]         unused_total;
   logic [PICKS_W-1:0]         pick_cap;

   rsp_type                    expected_q [$];

   initial begin
      n_errors  = 0;
      n_pending = 0;
   end

   task automatic flag_error(input string msg);
      $display("[%0t] wrs mismatch: %s", $realtime, msg);
      n_errors = n_errors + 1;
   endtask

   // Update the state for one accepted item and return the result it must give.
   function automatic rsp_type apply_item(input req_type r);
      rsp_type            o;
      logic [TOTAL_W:0]   sum;
      logic [TOTAL_W:0]   cum;
      int unsigned        i;
      int unsigned        pick;
      bit                 found;
      bit                 done;
      bit                 first_mode;
      o = '0;
      case (op_type'(r.opcode))
         OP_CLEAR: begin
            used_v       = '0;
            loaded       = 0;
            unused_total = '0;
            picks        = 0;
         end
         OP_APPEND: begin
            if (loaded >= MAX_ENTRIES_DEF) begin
               o.remaining_total = unused_total;
               o.status          = STAT_FULL;
            end else begin
               weights_m[loaded] = r.weight;
               used_v[loaded]    = 1'b0;
               sum               = {1'b0, unused_total} + r.weight;
               unused_total      = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
               o.index           = loaded[IDX_OUT_W-1:0];
               o.remaining_total = unused_total;
               loaded            = loaded + 1;
            end
         end
         OP_SELECT: begin
            if (picks >= pick_cap) begin
               o.remaining_total = unused_total;
               o.status          = STAT_LIMIT;
            end else begin
               // Few entries: take them in load order; otherwise walk the running sum.
               first_mode = (loaded <= pick_cap);
               found      = 1'b0;
               done       = 1'b0;
               pick       = 0;
               cum        = '0;
               for (i = 0; i < loaded && !done; i++) begin
                  if (!used_v[i]) begin
                     pick  = i;
                     found = 1'b1;
                     if (first_mode) begin
                        done = 1'b1;
                     end else begin
                        cum = cum + weights_m[i];
                        if (cum >= {1'b0, r.draw}) done = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  o.remaining_total = unused_total;
                  o.status          = STAT_EMPTY;
               end else begin
                  used_v[pick]      = 1'b1;
                  unused_total      = (unused_total >= weights_m[pick]) ?
                                      unused_total - weights_m[pick] : '0;
                  picks             = picks + 1;
                  o.index           = pick[IDX_OUT_W-1:0];
                  o.picked_weight   = weights_m[pick];
                  o.remaining_total = unused_total;
               end
            end
         end
         default: o.remaining_total = unused_total;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         used_v       = '0;
         loaded       = 0;
         picks        = 0;
         unused_total = '0;
         pick_cap     = '0;
         expected_q.delete();
      end else begin
         // Retire the result first: it always belongs to an earlier transfer.
         if (rsp_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
               flag_error($sformatf("result with nothing outstanding: %p", rsp_data));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.index !== want.index)
                  flag_error($sformatf("index got %0d want %0d",
                                       rsp_data.index, want.index));
               if (rsp_data.picked_weight !== want.picked_weight)
                  flag_error($sformatf("picked_weight got %0d want %0d",
                                       rsp_data.picked_weight, want.picked_weight));
               if (rsp_data.remaining_total !== want.remaining_total)
                  flag_error($sformatf("remaining_total got %0d want %0d",
                                       rsp_data.remaining_total, want.remaining_total));
               if (rsp_data.status !== want.status)
                  flag_error($sformatf("status got %0d want %0d",
                                       rsp_data.status, want.status));
            end
         end
         if (csr_wr_en === 1'b1) pick_cap = csr_wr_data;
         if (start === 1'b1 && busy === 1'b0) expected_q.push_back(apply_item(req_data));
      end
      n_pending = expected_q.size();
   end

endmodule

// ----- test/tb_top.sv -----
// Stimulus and verdict for the weighted roulette selector testbench.
module tb_top;
   import wrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   req_type            req_data    = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [PICKS_W-1:0] csr_wr_data = '0;

   int                 n_errors;
   int                 n_pending;
   bit                 steady;
   int unsigned        items;
   int unsigned        appended_sum;

   weighted_roulette_select DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   wrs_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .n_errors    (n_errors),
      .n_pending   (n_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

   // Present one item and hold it until the transfer happens; start stays high.
   task automatic send(input op_type op, input logic [WEIGHT_W-1:0] w,
                       input logic [TOTAL_W-1:0] d);
      req_type r;
      r.opcode   = op;
      r.weight   = w;
      r.draw     = d;
      start     <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (op != OP_NOP) items = items + 1;
   endtask

   task automatic pause();
      int r;
      int gap;
      r   = $urandom_range(99, 0);
      gap = (steady || r < 55) ? 0 : (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and wait until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      wait (n_pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cap(input logic [PICKS_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int r;
      r = $urandom_range(99, 0);
      if (r < 10) return '0;
      if (r < 25) return '1;
      if (r < 45) return WEIGHT_W'($urandom);
      return WEIGHT_W'($urandom_range(500, 1));
   endfunction

   function automatic logic [TOTAL_W-1:0] pick_draw(input int unsigned sum);
      int unsigned hi;
      int          r;
      hi = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
      r  = $urandom_range(99, 0);
      if (r < 5)  return '0;
      if (r < 10) return TOTAL_W'(hi);
      if (r < 25) return TOTAL_W'($urandom);
      return TOTAL_W'($urandom_range(hi, 0));
   endfunction

   initial begin
      int unsigned n;
      int unsigned cap;
      int unsigned n_sel;
      int unsigned k;
      int          r;
      logic [WEIGHT_W-1:0] w;
      items = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Pick limit is checked ahead of the empty table; unused opcode is ignored.
      send(OP_SELECT, '0, '0);
      send(OP_NOP, '1, '1);
      send(OP_APPEND, '1, '0);
      send(OP_APPEND, '0, '1);
      send(OP_NOP, '0, '0);
      // Load-order picks until the table runs dry.
      write_cap(7'd64);
      send(OP_SELECT, '0, '1);
      send(OP_SELECT, '0, '0);
      send(OP_SELECT, '0, '0);
      send(OP_CLEAR, '1, '1);
      // Roulette walk: exact boundary, draw above any total, then the limit.
      write_cap(7'd2);
      send(OP_APPEND, 16'd5, '0);
      send(OP_APPEND, 16'd10, '0);
      send(OP_APPEND, 16'd20, '0);
      send(OP_SELECT, '0, 22'd15);
      send(OP_SELECT, '0, TOTAL_MAX);
      send(OP_SELECT, '0, '0);
      send(OP_CLEAR, '0, '0);
      send(OP_SELECT, '0, '0);

      while (items < 1650) begin
         r = $urandom_range(99, 0);
         n = (r < 3) ? 0 :
             (r < 9 || items < 40) ? $urandom_range(66, 63) :
             (r < 22) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         r = $urandom_range(99, 0);
         cap = (r < 5) ? 0 : (r < 12) ? 64 :
               (r < 70 && n > 1) ? $urandom_range(n - 1, 1) :
               $urandom_range(64, (n > 64) ? 64 : n);
         if ($urandom_range(99, 0) < 85) write_cap(cap[PICKS_W-1:0]);
         steady = ($urandom_range(3, 0) == 0);
         appended_sum = 0;
         send(OP_CLEAR, WEIGHT_W'($urandom), TOTAL_W'($urandom));
         pause();
         for (k = 0; k < n; k++) begin
            w = pick_weight();
            appended_sum += w;
            send(OP_APPEND, w, TOTAL_W'($urandom));
            pause();
         end
         n_sel = ((cap < n) ? cap : n) + $urandom_range(2, 0);
         if (n_sel == 0) n_sel = 1;
         for (k = 0; k < n_sel; k++) begin
            r = $urandom_range(99, 0);
            if (r < 4) begin
               send(OP_NOP, WEIGHT_W'($urandom), TOTAL_W'($urandom));
               pause();
            end else if (r < 8) begin
               w = pick_weight();
               appended_sum += w;
               send(OP_APPEND, w, TOTAL_W'($urandom));
               pause();
            end
            send(OP_SELECT, WEIGHT_W'($urandom), pick_draw(appended_sum));
            pause();
         end
      end

      drain();
      repeat (80) @(posedge clock);
      if (n_errors == 0 && n_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
